// ===== design/lbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types, codes and helpers of the landmark bar decoder.
// ----------------------------------------------------------------------------
package lbd_pkg;

    localparam int MAX_EDGES_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 3'd4;

    localparam logic [7:0]  RST_SMALL_LEN = 8'd5;
    localparam logic [7:0]  RST_BIG_LEN   = 8'd10;
    localparam logic [7:0]  RST_MARGIN    = 8'd2;
    localparam logic [15:0] RST_END_GAP   = 16'd30;
    localparam logic [4:0]  RST_MIN_COUNT = 5'd4;

    localparam logic [2:0] EDGE_OK         = 3'd0;
    localparam logic [2:0] EDGE_BAD_START  = 3'd1;
    localparam logic [2:0] EDGE_DIR_CHANGE = 3'd2;
    localparam logic [2:0] EDGE_BAD_LEN    = 3'd3;
    localparam logic [2:0] EDGE_FULL       = 3'd4;

    localparam logic [1:0] LM_NONE    = 2'd0;
    localparam logic [1:0] LM_IDENT   = 2'd1;
    localparam logic [1:0] LM_UNKNOWN = 2'd2;

    typedef struct packed {
        logic        color;
        logic [15:0] pos;
        logic [7:0]  ticks;
    } t_edge;

    typedef struct packed {
        logic [7:0]  small_len;
        logic [7:0]  big_len;
        logic [7:0]  margin;
        logic [15:0] end_gap;
        logic [4:0]  min_count;
    } t_cfg;

    function automatic logic [15:0] dist16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic in_window(input logic [15:0] len, input logic [7:0] nom,
                                       input logic [7:0] margin);
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        logic signed [17:0] l;
        lo = $signed({10'd0, nom}) - $signed({10'd0, margin});
        hi = $signed({10'd0, nom}) + $signed({10'd0, margin});
        l  = $signed({2'd0, len});
        return (l >= lo) && (l <= hi);
    endfunction

endpackage

// ===== design/lbd_edge_mem.sv =====
// ----------------------------------------------------------------------------
// lbd_edge_mem
// Edge store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbd_edge_mem #(
    parameter int DEPTH = lbd_pkg::MAX_EDGES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  lbd_pkg::t_edge       i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output lbd_pkg::t_edge       o_rdata
);
    import lbd_pkg::*;

    t_edge r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/lbd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lbd_cfg_regs
// Configuration registers with write-only access.
// ----------------------------------------------------------------------------
module lbd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [lbd_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [lbd_pkg::CFG_DATA_W-1:0]    i_data,
    output lbd_pkg::t_cfg                     o_cfg
);
    import lbd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_len <= RST_SMALL_LEN;
            r_cfg.big_len   <= RST_BIG_LEN;
            r_cfg.margin    <= RST_MARGIN;
            r_cfg.end_gap   <= RST_END_GAP;
            r_cfg.min_count <= RST_MIN_COUNT;
        end else if (i_we) begin
            case (i_idx)
                REG_SMALL_LEN: r_cfg.small_len <= i_data[7:0];
                REG_BIG_LEN:   r_cfg.big_len   <= i_data[7:0];
                REG_MARGIN:    r_cfg.margin    <= i_data[7:0];
                REG_END_GAP:   r_cfg.end_gap   <= i_data;
                REG_MIN_COUNT: r_cfg.min_count <= i_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/landmark_bar_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// landmark_bar_decoder_unit
// Edge and poll beats pass through ST_EDGE or ST_POLL to ST_OUT; a poll beat that
// decodes stored edges walks them in ST_WALK first (one edge store read per cycle).
// One beat at a time; the next beat is taken once the result sits in the output
// register, which holds while the previous result waits. Reset clears the edge
// count, direction and output valid and loads the configuration defaults;
// store contents stay undefined.
// ----------------------------------------------------------------------------
module landmark_bar_decoder_unit #(
    parameter int MAX_EDGES = lbd_pkg::MAX_EDGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] bar_color, [16:1] line_position, [24:17] sub_cm_ticks
    input  logic [31:0]                     s_axis_tdata,
    // [0] req_type
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] edge_status, [4:3] landmark_status, [8:5] landmark_id,
    // [24:9] landmark_position
    output logic [31:0]                     m_axis_tdata
);
    import lbd_pkg::*;

    localparam int AW   = $clog2(MAX_EDGES);
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {ST_IDLE, ST_EDGE, ST_POLL, ST_WALK, ST_OUT} t_state;

    t_state          r_state;
    t_cfg            cfg;
    t_edge           mem_rdata;
    t_edge           mem_wdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;

    logic            r_color;
    logic [15:0]     r_pos;
    logic [7:0]      r_tk;
    logic [CW-1:0]   r_count;
    logic            r_dir;
    logic [CW-1:0]   r_n;
    logic [CW-1:0]   r_j;
    logic [7:0]      r_prev;
    logic [15:0]     r_first;
    logic            r_ok;
    logic [2:0]      r_res_edge;
    logic [1:0]      r_res_lm;
    logic [3:0]      r_res_id;
    logic [15:0]     r_res_pos;
    logic            r_m_valid;
    logic [31:0]     r_m_data;

    logic            s_hs;
    logic [CW-1:0]   w_cnt_m1;
    logic [CW-1:0]   w_jn;
    logic [CW-1:0]   w_walk_addr;
    logic [CW-1:0]   w_init_addr;
    logic [15:0]     w_len;
    logic            w_len_ok;
    logic            w_dir;
    logic            w_dir_ok;
    logic            w_full;
    logic            w_append;
    logic [2:0]      w_edge_status;
    logic [CW-1:0]   n_count;
    logic            w_poll_skip;
    logic            w_gap_short;
    logic [7:0]      w_wid;
    logic            w_first_bar;
    logic            w_chk;
    logic            w_last;
    logic [CW-1:0]   w_bars;
    logic [CW+3:0]   w_bars_ext;

    lbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lbd_edge_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_hs          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign w_cnt_m1    = r_count - CW'(1);
    assign w_jn        = r_j + CW'(1);
    assign w_walk_addr = r_dir ? (r_n - CW'(1) - w_jn) : w_jn;
    assign w_init_addr = r_dir ? w_cnt_m1 : '0;

    always_comb begin
        case (r_state)
            ST_POLL: mem_raddr = w_init_addr[AW-1:0];
            ST_WALK: mem_raddr = w_walk_addr[AW-1:0];
            default: mem_raddr = w_cnt_m1[AW-1:0];
        endcase
    end

    // edge decision against the last stored edge
    always_comb begin
        w_len    = dist16(r_pos, mem_rdata.pos);
        w_len_ok = in_window(w_len, cfg.small_len, cfg.margin)
                || in_window(w_len, cfg.big_len, cfg.margin);
        if (r_pos == mem_rdata.pos) begin
            w_dir = (r_tk >= mem_rdata.ticks) ? 1'b0 : 1'b1;
        end else begin
            w_dir = (r_pos > mem_rdata.pos) ? 1'b0 : 1'b1;
        end
        w_dir_ok = (r_count == CW'(1)) || (w_dir == r_dir);
        w_full   = (r_count >= CW'(MAX_EDGES));
        w_append = (r_count != '0) && !w_full && w_len_ok && w_dir_ok;
        if (r_count == '0) begin
            w_edge_status = r_color ? EDGE_OK : EDGE_BAD_START;
        end else if (w_full) begin
            w_edge_status = EDGE_FULL;
        end else if (!w_len_ok) begin
            w_edge_status = EDGE_BAD_LEN;
        end else if (!w_dir_ok) begin
            w_edge_status = EDGE_DIR_CHANGE;
        end else begin
            w_edge_status = EDGE_OK;
        end
        n_count = w_append ? (r_count + CW'(1)) : (r_color ? CW'(1) : '0);
    end

    always_comb begin
        mem_we          = (r_state == ST_EDGE) && (w_append || r_color);
        mem_waddr       = w_append ? r_count[AW-1:0] : '0;
        mem_wdata.color = r_color;
        mem_wdata.pos   = r_pos;
        mem_wdata.ticks = r_tk;
    end

    // poll and walk decisions
    always_comb begin
        w_poll_skip = (r_count == '0) || (CMPW'(r_count) < CMPW'(cfg.min_count));
        w_gap_short = dist16(r_pos, mem_rdata.pos) < cfg.end_gap;
        w_wid       = r_j[0] ? (mem_rdata.pos[7:0] - r_prev) : 8'd0;
        w_first_bar = (r_j[CW-1:1] == '0);
        w_chk       = w_first_bar ? in_window({8'd0, w_wid}, cfg.big_len, cfg.margin)
                                  : in_window({8'd0, w_wid}, cfg.small_len, cfg.margin);
        w_last      = (r_j == r_n - CW'(1));
        w_bars      = (r_j >> 1) + CW'(1);
        w_bars_ext  = {4'd0, w_bars};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dir     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_hs) begin
                        r_color <= s_axis_tdata[0];
                        r_pos   <= s_axis_tdata[16:1];
                        r_tk    <= s_axis_tdata[24:17];
                        r_state <= s_axis_tuser[0] ? ST_POLL : ST_EDGE;
                    end
                end
                ST_EDGE: begin
                    r_count    <= n_count;
                    if (w_append && (r_count == CW'(1))) begin
                        r_dir <= w_dir;
                    end
                    r_res_edge <= w_edge_status;
                    r_res_lm   <= LM_NONE;
                    r_res_id   <= '0;
                    r_res_pos  <= '0;
                    r_state    <= ST_OUT;
                end
                ST_POLL: begin
                    r_res_edge <= EDGE_OK;
                    r_res_lm   <= LM_NONE;
                    r_res_id   <= '0;
                    r_res_pos  <= '0;
                    r_n        <= r_count;
                    r_j        <= '0;
                    r_ok       <= 1'b1;
                    if (w_poll_skip || w_gap_short) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_count <= '0;
                        r_state <= mem_rdata.color ? ST_OUT : ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (r_j == '0) begin
                        r_first <= mem_rdata.pos;
                    end
                    r_prev <= mem_rdata.pos[7:0];
                    r_j    <= w_jn;
                    if (!r_j[0] && !w_last) begin
                        r_ok <= r_ok;
                    end else begin
                        r_ok <= r_ok && w_chk;
                    end
                    if (w_last) begin
                        if (r_ok && w_chk) begin
                            r_res_lm <= LM_IDENT;
                            r_res_id <= w_bars_ext[3:0];
                        end else begin
                            r_res_lm <= LM_UNKNOWN;
                            r_res_id <= '0;
                        end
                        r_res_pos <= (r_j == '0) ? mem_rdata.pos : r_first;
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= {7'd0, r_res_pos, r_res_id, r_res_lm, r_res_edge};
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EDGES))
        else $error("edge count above store depth");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_j < r_n))
        else $error("walk index past stored edges");

    a_one_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == EDGE_OK || m_axis_tdata[4:3] == LM_NONE))
        else $error("edge and landmark status both set");

    a_walk_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_count == '0))
        else $error("store not cleared during decode");
`endif

endmodule
